// File: design/five_channel_led_fader_assert.svh
// Assertion macros for the fader RTL.
`ifndef FIVE_CHANNEL_LED_FADER_ASSERT_SVH
`define FIVE_CHANNEL_LED_FADER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fcf_pkg.sv
// Shared types and constants for the five channel LED fader.
package fcf_pkg;

    localparam int NUM_LANES      = 5;
    localparam int COLOR_W        = 8;
    localparam int BRIGHT_W       = 9;
    localparam int DUR_W          = 16;
    localparam int FADE_STEPS_DEF = 256;
    localparam int ROUND_HALF     = 128;
    localparam int TICK_SCALE     = 255;

    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [BRIGHT_W-1:0] bright_t;
    typedef logic [DUR_W-1:0]    dur_t;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FADE = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    // Per-item commands broadcast to every lane.
    typedef struct packed {
        logic load_goal;
        logic load_now;
        logic step;
    } lane_cmd_t;

    // Fade clock status seen by the top level.
    typedef struct packed {
        logic busy;
        logic len_zero;
    } ctrl_stat_t;

endpackage

// File: design/five_channel_led_fader.sv
// Top level of the five channel LED fader: lanes, fade clock and output register.
//
// Five color lanes (red, green, blue, white, yellow) run side by side, each scaling
// its requested color by brightness/256 with round half up (saturating at 255 for
// brightness above full) and holding its own level and target. A shared fade clock
// decodes the op: set loads levels at once, fade latches targets and the duration,
// and each tick advances the clock so that whenever elapsed_ms * 255 reaches the
// duration every lane moves one unit toward its target, never past it, for
// FADE_STEPS steps. A zero duration jumps straight to the target, and any new set
// or fade cancels a running fade. Every accepted item yields exactly one result
// item: the five duty levels and the fading flag after that item. Throughput is one
// item per clock cycle while the consumer keeps up: all state moves in the accepting
// cycle (one 8x9 multiply per lane and one 24-bit compare in the fade clock), and
// the result lands in an output register. in_ready is high whenever that register
// is empty or its item is taken in the same cycle, so a stalled consumer holds the
// result while the input side waits only one item deep.
module five_channel_led_fader
    import fcf_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [7:0] white_in,
    input  logic [7:0] yellow_in,
    input  logic [8:0] brightness,
    input  logic [15:0] duration_ms,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_duty,
    output logic [7:0] green_duty,
    output logic [7:0] blue_duty,
    output logic [7:0] white_duty,
    output logic [7:0] yellow_duty,
    output logic       fading
);

    `include "five_channel_led_fader_assert.svh"

    logic       in_fire;
    lane_cmd_t  cmd;
    logic       busy_next;
    ctrl_stat_t stat;
    color_t     color_in   [NUM_LANES];
    color_t     lane_level [NUM_LANES];
    color_t     duty       [NUM_LANES];

    assign in_fire = in_valid && in_ready;

    // Lane order: red, green, blue, white, yellow.
    assign color_in[0] = red_in;
    assign color_in[1] = green_in;
    assign color_in[2] = blue_in;
    assign color_in[3] = white_in;
    assign color_in[4] = yellow_in;

    assign red_duty    = duty[0];
    assign green_duty  = duty[1];
    assign blue_duty   = duty[2];
    assign white_duty  = duty[3];
    assign yellow_duty = duty[4];

    // Decode the op and run the fade clock.
    fcf_ctrl #(
        .FADE_STEPS (FADE_STEPS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .op          (op),
        .duration_ms (duration_ms),
        .cmd         (cmd),
        .busy_next   (busy_next),
        .stat        (stat)
    );

    // One lane per color, all driven by the same command.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        fcf_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .color_in   (color_in[i]),
            .brightness (brightness),
            .cmd        (cmd),
            .level_next (lane_level[i])
        );
    end

    // Merge lane levels and the fade flag into the held result item.
    fcf_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .lane_level (lane_level),
        .busy_next  (busy_next),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .in_ready   (in_ready),
        .duty       (duty),
        .fading     (fading)
    );

    // An accepted item always shows up as a held result next cycle.
    `FCF_ASSERT_NEXT(a_item_to_result, in_fire, out_valid, "accepted item produced no result")

    // A running fade always has a nonzero duration latched.
    `FCF_ASSERT_NOW(a_busy_len, stat.busy, !stat.len_zero, "fade running with zero duration")

    // A tick while idle must not step any lane.
    `FCF_ASSERT_NOW(a_idle_tick, in_fire && (op == OP_TICK) && !stat.busy, !cmd.step,
        "step issued while no fade is running")

endmodule

// File: design/fcf_lane.sv
// One color lane: brightness scaling, target and level registers, one-unit step.
module fcf_lane
    import fcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  color_t    color_in,
    input  bright_t   brightness,
    input  lane_cmd_t cmd,
    output color_t    level_next
);

    localparam int PROD_W = COLOR_W + BRIGHT_W;

    color_t level_reg;
    color_t goal_reg;
    color_t goal_next;
    color_t scaled;

    logic [PROD_W-1:0]  prod;
    logic [BRIGHT_W-1:0] rounded;

    // Round half up, saturate when brightness exceeds full scale.
    always_comb
    begin
        prod    = PROD_W'(color_in) * PROD_W'(brightness) + PROD_W'(ROUND_HALF);
        rounded = prod[PROD_W-1:COLOR_W];
        scaled  = rounded[BRIGHT_W-1] ? '1 : rounded[COLOR_W-1:0];
    end

    always_comb
    begin
        goal_next  = cmd.load_goal ? scaled : goal_reg;
        level_next = level_reg;
        if (cmd.load_now)
        begin
            level_next = scaled;
        end
        else if (cmd.step)
        begin
            if (level_reg < goal_reg)
            begin
                level_next = level_reg + 1'b1;
            end
            else if (level_reg > goal_reg)
            begin
                level_next = level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            goal_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            goal_reg  <= goal_next;
        end
    end

endmodule

// File: design/fcf_ctrl.sv
// Fade clock: op decode, elapsed time, step count and busy flag.
module fcf_ctrl
    import fcf_pkg::*;
#(
    parameter int FADE_STEPS = FADE_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [1:0] op,
    input  dur_t       duration_ms,
    output lane_cmd_t  cmd,
    output logic       busy_next,
    output ctrl_stat_t stat
);

    localparam int STEP_W = $clog2(FADE_STEPS + 1);
    localparam int PROD_W = DUR_W + COLOR_W;

    op_t               op_code;
    logic              busy_reg;
    dur_t              elapsed_reg;
    dur_t              elapsed_next;
    dur_t              len_reg;
    dur_t              len_next;
    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W-1:0] steps_next;
    logic [STEP_W-1:0] steps_inc;
    dur_t              elapsed_inc;
    logic [PROD_W-1:0] scaled_ms;

    assign op_code = op_t'(op);
    assign stat    = '{busy: busy_reg, len_zero: (len_reg == '0)};

    always_comb
    begin
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        // elapsed * 255 as a shift and subtract
        scaled_ms   = (PROD_W'(elapsed_inc) << COLOR_W) - PROD_W'(elapsed_inc);
        steps_inc   = steps_reg + 1'b1;
    end

    always_comb
    begin
        cmd          = '0;
        busy_next    = busy_reg;
        elapsed_next = elapsed_reg;
        len_next     = len_reg;
        steps_next   = steps_reg;
        if (in_fire)
        begin
            unique case (op_code)
                OP_SET:
                begin
                    cmd.load_goal = 1'b1;
                    cmd.load_now  = 1'b1;
                    busy_next     = 1'b0;
                    steps_next    = '0;
                    elapsed_next  = '0;
                end
                OP_FADE:
                begin
                    cmd.load_goal = 1'b1;
                    len_next      = duration_ms;
                    steps_next    = '0;
                    elapsed_next  = '0;
                    if (duration_ms == '0)
                    begin
                        cmd.load_now = 1'b1;
                        busy_next    = 1'b0;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        if (scaled_ms >= PROD_W'(len_reg))
                        begin
                            cmd.step     = 1'b1;
                            elapsed_next = '0;
                            steps_next   = steps_inc;
                            if (steps_inc >= STEP_W'(FADE_STEPS))
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        else
                        begin
                            elapsed_next = elapsed_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            elapsed_reg <= '0;
            len_reg     <= '0;
            steps_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            elapsed_reg <= elapsed_next;
            len_reg     <= len_next;
            steps_reg   <= steps_next;
        end
    end

endmodule

// File: design/fcf_merge.sv
// Output register: gather the lane levels and fade flag into one result item.
module fcf_merge
    import fcf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_fire,
    input  color_t lane_level [NUM_LANES],
    input  logic   busy_next,
    input  logic   out_ready,
    output logic   out_valid,
    output logic   in_ready,
    output color_t duty [NUM_LANES],
    output logic   fading
);

    logic   valid_reg;
    logic   valid_next;
    color_t duty_reg [NUM_LANES];
    logic   fading_reg;

    // Take a new item whenever the held result is absent or leaving.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_fire ? 1'b1 : (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign duty       = duty_reg;
    assign fading     = fading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            duty_reg   <= lane_level;
            fading_reg <= busy_next;
        end
    end

endmodule
